// ===== sv/spq_pkg.sv =====
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 8;
	localparam int PRIO_W    = 8;
	localparam int CNT_OUT_W = 5;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} spq_entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
		logic occ;
		logic left_place;
	} spq_cell_ctrl_t;

endpackage

// ===== sv/spq_ifs.sv =====
interface spq_in_if;
	import spq_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [ID_W-1:0]   proc_id;
	logic [PRIO_W-1:0] priority_req;

	modport source (output valid, func, proc_id, priority_req, input ready);
	modport sink   (input valid, func, proc_id, priority_req, output ready);
endinterface

interface spq_out_if;
	import spq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 deq_valid;
	logic [ID_W-1:0]      out_id;
	logic [PRIO_W-1:0]    out_priority;
	logic                 rejected;
	logic                 is_empty;
	logic [CNT_OUT_W-1:0] count;

	modport source (output valid, deq_valid, out_id, out_priority, rejected, is_empty, count,
		input ready);
	modport sink   (input valid, deq_valid, out_id, out_priority, rejected, is_empty, count,
		output ready);
endinterface

// ===== sv/spq_cell.sv =====
module spq_cell (
	input  logic                    clk,
	input  spq_pkg::spq_cell_ctrl_t ctrl,
	input  spq_pkg::spq_entry_t     new_entry,
	input  spq_pkg::spq_entry_t     left_entry,
	input  spq_pkg::spq_entry_t     right_entry,
	output spq_pkg::spq_entry_t     entry,
	output logic                    place
);
	import spq_pkg::*;

	spq_entry_t entry_q;

	// new word belongs at or before this cell unless this cell holds a lower-or-equal prio
	assign place = !(ctrl.occ && (entry_q.prio <= new_entry.prio));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			entry_q <= right_entry;
		end else if (ctrl.enq && place) begin
			if (ctrl.left_place) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

// ===== sv/stable_min_priority_queue.sv =====
// channel  dir  handshake    word
// req      in   valid/ready  func, proc_id, priority_req
// rsp      out  valid/ready  deq_valid, out_id, out_priority, rejected, is_empty, count
//
// One word per cycle while req.ready is high: each word is applied to the sorted cell row in the cycle it is
// accepted and its result sits in the rsp register the next cycle.
// req.ready is high while the rsp register is empty or being drained in the same cycle.
// Reset empties the queue at once (count cleared); no clearing pass.
// Cells stay ordered by priority, ties by arrival, so cell 0 is always the next to leave.
module stable_min_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             full;
	logic             empty;
	logic             accept;
	logic             do_enq;
	logic             do_deq;
	logic             rej;

	spq_entry_t     new_entry;
	spq_entry_t     cell_entry [DEPTH];
	logic           cell_place [DEPTH];
	spq_cell_ctrl_t cell_ctrl  [DEPTH];

	logic                 rsp_valid_q;
	logic                 deq_valid_q;
	logic [ID_W-1:0]      out_id_q;
	logic [PRIO_W-1:0]    out_priority_q;
	logic                 rejected_q;
	logic                 is_empty_q;
	logic [CNT_OUT_W-1:0] count_out_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign accept = req.valid && req.ready;
	assign do_enq = accept && (req.func == FUNC_ENQ) && !full;
	assign do_deq = accept && (req.func == FUNC_DEQ) && !empty;
	assign rej    = accept && (req.func == FUNC_ENQ) && full;

	assign new_entry.id   = req.proc_id;
	assign new_entry.prio = req.priority_req;

	always_comb begin
		priority if (do_enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctrl[i].enq        = do_enq;
		assign cell_ctrl[i].deq        = do_deq;
		assign cell_ctrl[i].occ        = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign cell_ctrl[i].left_place = 1'b0;
		end else begin : g_body
			assign cell_ctrl[i].left_place = cell_place[i-1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[i]),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
			.right_entry (cell_entry[(i == DEPTH-1) ? i : i+1]),
			.entry       (cell_entry[i]),
			.place       (cell_place[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign req.ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deq_valid_q    <= do_deq;
			out_id_q       <= do_deq ? cell_entry[0].id : '0;
			out_priority_q <= do_deq ? cell_entry[0].prio : '0;
			rejected_q     <= rej;
			is_empty_q     <= (count_nxt == '0);
			count_out_q    <= CNT_OUT_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.deq_valid    = deq_valid_q;
	assign rsp.out_id       = out_id_q;
	assign rsp.out_priority = out_priority_q;
	assign rsp.rejected     = rejected_q;
	assign rsp.is_empty     = is_empty_q;
	assign rsp.count        = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_pop_reported: assert property (@(posedge clk) disable iff (!arst_n)
		do_deq |=> rsp.valid && rsp.deq_valid && !rsp.rejected)
		else $error("dequeue of held entry not reported");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		rej |=> rsp.valid && rsp.rejected && $stable(count_q))
		else $error("rejected enqueue changed state");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
		else $error("head cells out of order");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
	logic                          deq_valid;
	logic [spq_pkg::ID_W-1:0]      id;
	logic [spq_pkg::PRIO_W-1:0]    prio;
	logic                          rejected;
	logic                          is_empty;
	logic [spq_pkg::CNT_OUT_W-1:0] count;
} sched_result_t;

class ready_queue_scoreboard;
	spq_pkg::spq_entry_t held[$];
	sched_result_t       owed[$];
	int                  depth;
	int unsigned         errors, checked;
	int unsigned         n_enq, n_rej, n_deq, n_deq_empty, peak;

	function new(int d);
		depth = d;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	// apply an accepted request word to the model queue and owe its result
	function void note_word(logic func, logic [7:0] id, logic [7:0] prio);
		sched_result_t       r;
		spq_pkg::spq_entry_t e;
		int                  best;
		r = '0;
		if (func == spq_pkg::FUNC_ENQ) begin
			if (held.size() < depth) begin
				e.id = id;
				e.prio = prio;
				held.push_back(e);
				n_enq++;
			end else begin
				r.rejected = 1'b1;
				n_rej++;
			end
		end else if (held.size() > 0) begin
			// strict less-than keeps the oldest of equal priorities
			best = 0;
			for (int i = 1; i < held.size(); i++)
				if (held[i].prio < held[best].prio)
					best = i;
			r.deq_valid = 1'b1;
			r.id = held[best].id;
			r.prio = held[best].prio;
			held.delete(best);
			n_deq++;
		end else begin
			n_deq_empty++;
		end
		r.is_empty = (held.size() == 0);
		r.count = spq_pkg::CNT_OUT_W'(held.size());
		if (held.size() > peak)
			peak = held.size();
		owed.push_back(r);
	endfunction

	function void check_word(sched_result_t got);
		sched_result_t want;
		checked++;
		if (owed.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%t: unexpected rsp word dv=%0b id=%0h pr=%0h rej=%0b emp=%0b cnt=%0d",
					$realtime, got.deq_valid, got.id, got.prio, got.rejected, got.is_empty,
					got.count);
			return;
		end
		want = owed.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("%t: rsp mismatch #%0d", $realtime, checked);
				$display("  expected dv=%0b id=%0h pr=%0h rej=%0b emp=%0b cnt=%0d",
					want.deq_valid, want.id, want.prio, want.rejected, want.is_empty, want.count);
				$display("  actual   dv=%0b id=%0h pr=%0h rej=%0b emp=%0b cnt=%0d",
					got.deq_valid, got.id, got.prio, got.rejected, got.is_empty, got.count);
			end
		end
	endfunction
endclass

module tb;
	import spq_pkg::*;

	localparam int PHASE_WORDS = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_req = 0;
	int   hold_left = 0;

	ready_queue_scoreboard sb = new(DEPTH_DEF);

	spq_in_if  req();
	spq_out_if rsp();

	stable_min_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_word('{rsp.deq_valid, rsp.out_id, rsp.out_priority, rsp.rejected,
				rsp.is_empty, rsp.count});
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(logic func, logic [7:0] id, logic [7:0] prio);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.proc_id <= id;
		req.priority_req <= prio;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_word(func, id, prio);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 3));       // dense ties
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [7:0] d_id [16];
		logic [7:0] d_pr [16];
		int enq_pct, run_left;
		logic func;

		d_id = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'hAA, 8'h55, 8'h10,
			8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18};
		d_pr = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'h00, 8'h55, 8'hAA, 8'h80,
			8'hFF, 8'h01, 8'h7F, 8'hFE, 8'h00, 8'h40, 8'h40, 8'h02};
		req.valid = 1'b0;
		req.func = FUNC_ENQ;
		req.proc_id = '0;
		req.priority_req = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty pop, fill with extremes and ties, push on full, partial drain
		send_word(FUNC_DEQ, 8'hFF, 8'hFF);
		for (int i = 0; i < 16; i++)
			send_word(FUNC_ENQ, d_id[i], d_pr[i]);
		send_word(FUNC_ENQ, 8'hEE, 8'h00);
		for (int i = 0; i < 6; i++)
			send_word(FUNC_DEQ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		wait_drained();

		enq_pct = 50;
		run_left = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// bias runs toward filling or draining so full and empty both recur
				if (run_left == 0) begin
					run_left = $urandom_range(20, 80);
					case ($urandom_range(0, 2))
						0: enq_pct = 25;
						1: enq_pct = 50;
						default: enq_pct = 80;
					endcase
				end
				run_left--;
				if (n == 100 || (ph == 3 && n == 200))
					hold_req = 40;
				func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				send_word(func, 8'($urandom_range(0, 255)), pick_prio());
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		$display("Ran %0d enqueues (%0d dropped on full) and %0d dequeues (%0d on empty)",
			sb.n_enq, sb.n_rej, sb.n_deq, sb.n_deq_empty);
		$display("Peak fill %0d of %0d, %0d results checked, %0d mismatches",
			sb.peak, DEPTH_DEF, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
